// ===== rtl/lpmf_pkg.sv =====
// Shared constants, types and result layout of the length-prefixed message FIFO.
package lpmf_pkg;

	localparam int BUFFER_BYTES = 64;
	localparam int HEADER_BYTES = 4;

	localparam int LEN_W  = 8;
	localparam int IDX_W  = $clog2(BUFFER_BYTES);
	localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
	localparam int SUM_W  = ((CNT_W > LEN_W + 1) ? CNT_W : LEN_W + 1) + 1;
	localparam int HCNT_W = $clog2(HEADER_BYTES + 1);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [HCNT_W-1:0] hcnt_t;

	localparam logic [1:0] CMD_WR_REQ  = 2'd0;
	localparam logic [1:0] CMD_WR_DATA = 2'd1;
	localparam logic [1:0] CMD_RD_REQ  = 2'd2;
	localparam logic [1:0] CMD_RSVD    = 2'd3;

	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_BLOCK  = 2'd1;
	localparam logic [1:0] ST_ERROR  = 2'd2;
	localparam logic [1:0] ST_SEQ    = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		len_t       out_byte;
		logic       byte_valid;
		len_t       reported_length;
		logic       last;
	} res_t;

	typedef struct packed {
		logic we;
		idx_t waddr;
		len_t wdata;
		logic re;
		idx_t raddr;
	} mem_req_t;

endpackage

// ===== rtl/lpmf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lpmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lpmf_ctrl.sv =====
// Sequencer of the message FIFO: ring pointers, header handling and the result register.
module lpmf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	input  lpmf_pkg::len_t       msg_length,
	input  lpmf_pkg::len_t       in_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lpmf_pkg::res_t       out_res,
	output lpmf_pkg::mem_req_t   mem_req,
	input  lpmf_pkg::len_t       mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WR_HDR,
		S_RD_HDR,
		S_RD_CHK,
		S_RD_DATA
	} state_t;

	function automatic lpmf_pkg::idx_t idx_inc(input lpmf_pkg::idx_t idx);
		return (idx == lpmf_pkg::idx_t'(lpmf_pkg::BUFFER_BYTES - 1)) ?
			'0 : idx + 1'b1;
	endfunction

	state_t              state_q;
	lpmf_pkg::idx_t      ri_q;
	lpmf_pkg::idx_t      wi_q;
	lpmf_pkg::idx_t      rp_q;
	lpmf_pkg::len_t      exp_q;
	logic                wip_q;
	lpmf_pkg::hcnt_t     hcnt_q;
	lpmf_pkg::len_t      b0_q;
	logic                hi_q;
	lpmf_pkg::len_t      cap_q;
	lpmf_pkg::len_t      rem_q;
	logic                out_valid_q;
	lpmf_pkg::res_t      out_res_q;

	logic                out_free;
	logic                accept;
	lpmf_pkg::cnt_t      held;
	lpmf_pkg::sum_t      total;
	lpmf_pkg::sum_t      free_space;
	lpmf_pkg::sum_t      avail;
	logic                wr_err;
	logic                wr_blk;
	logic                rd_blk;
	logic                wr_req_go;
	logic                wr_data_go;
	logic                rd_req_go;
	logic                hdr_rd_issue;
	logic                chk_err;
	logic                chk_zero;
	logic                chk_data;
	logic                data_load;
	logic                data_more;
	lpmf_pkg::res_t      acc_res;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_comb begin
		held = (wi_q >= ri_q) ? lpmf_pkg::cnt_t'(wi_q - ri_q) :
			lpmf_pkg::cnt_t'(lpmf_pkg::BUFFER_BYTES) - lpmf_pkg::cnt_t'(ri_q - wi_q);
		total      = lpmf_pkg::sum_t'(lpmf_pkg::HEADER_BYTES) + lpmf_pkg::sum_t'(msg_length);
		free_space = lpmf_pkg::sum_t'(lpmf_pkg::BUFFER_BYTES - 1) - lpmf_pkg::sum_t'(held);
		avail      = lpmf_pkg::sum_t'(held) - lpmf_pkg::sum_t'(lpmf_pkg::HEADER_BYTES);
		wr_err     = total > lpmf_pkg::sum_t'(lpmf_pkg::BUFFER_BYTES);
		wr_blk     = free_space < total;
		rd_blk     = lpmf_pkg::sum_t'(held) < lpmf_pkg::sum_t'(lpmf_pkg::HEADER_BYTES);

		wr_req_go  = accept && (cmd == lpmf_pkg::CMD_WR_REQ) && !wip_q && !wr_err && !wr_blk;
		wr_data_go = accept && (cmd == lpmf_pkg::CMD_WR_DATA) && wip_q && (exp_q != '0);
		rd_req_go  = accept && (cmd == lpmf_pkg::CMD_RD_REQ) && !wip_q && !rd_blk;

		hdr_rd_issue = (state_q == S_RD_HDR) &&
			(hcnt_q < lpmf_pkg::hcnt_t'(lpmf_pkg::HEADER_BYTES));
		// The stored length is compared in full: any nonzero upper header byte is too large.
		chk_err   = hi_q || (b0_q > cap_q) || (lpmf_pkg::sum_t'(b0_q) > avail);
		chk_zero  = !chk_err && (b0_q == '0);
		chk_data  = (state_q == S_RD_CHK) && !chk_err && (b0_q != '0);
		data_load = (state_q == S_RD_DATA) && out_free;
		data_more = rem_q != lpmf_pkg::len_t'(1);

		mem_req.we    = wr_req_go || wr_data_go || (state_q == S_WR_HDR);
		mem_req.waddr = wi_q;
		mem_req.wdata = wr_req_go ? msg_length : (wr_data_go ? in_byte : '0);
		mem_req.re    = rd_req_go || hdr_rd_issue || chk_data || (data_load && data_more);
		mem_req.raddr = rd_req_go ? ri_q : rp_q;

		acc_res = '{status: lpmf_pkg::ST_SEQ, out_byte: '0, byte_valid: 1'b0,
			reported_length: '0, last: 1'b1};
		case (cmd)
			lpmf_pkg::CMD_WR_REQ: begin
				if (!wip_q) begin
					if (wr_err) begin
						acc_res.status = lpmf_pkg::ST_ERROR;
					end else if (wr_blk) begin
						acc_res.status = lpmf_pkg::ST_BLOCK;
					end else begin
						acc_res.status          = lpmf_pkg::ST_ACCEPT;
						acc_res.reported_length = msg_length;
					end
				end
			end
			lpmf_pkg::CMD_WR_DATA: begin
				if (wip_q && (exp_q != '0)) begin
					acc_res.status = lpmf_pkg::ST_ACCEPT;
				end
			end
			lpmf_pkg::CMD_RD_REQ: begin
				if (!wip_q && rd_blk) begin
					acc_res.status = lpmf_pkg::ST_BLOCK;
				end
			end
			default: begin
				acc_res.status = lpmf_pkg::ST_SEQ;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ri_q        <= '0;
			wi_q        <= '0;
			rp_q        <= '0;
			exp_q       <= '0;
			wip_q       <= 1'b0;
			hcnt_q      <= '0;
			b0_q        <= '0;
			hi_q        <= 1'b0;
			cap_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mem_req.we) begin
				wi_q <= idx_inc(wi_q);
			end
			case (state_q)
				S_IDLE: begin
					if (accept && !rd_req_go) begin
						out_res_q   <= acc_res;
						out_valid_q <= 1'b1;
					end
					if (wr_req_go) begin
						exp_q  <= msg_length;
						wip_q  <= msg_length != '0;
						hcnt_q <= lpmf_pkg::hcnt_t'(1);
						if (lpmf_pkg::HEADER_BYTES > 1) begin
							state_q <= S_WR_HDR;
						end
					end
					if (wr_data_go) begin
						exp_q <= exp_q - 1'b1;
						if (exp_q == lpmf_pkg::len_t'(1)) begin
							wip_q <= 1'b0;
						end
					end
					if (rd_req_go) begin
						rp_q    <= idx_inc(ri_q);
						hcnt_q  <= lpmf_pkg::hcnt_t'(1);
						hi_q    <= 1'b0;
						cap_q   <= msg_length;
						state_q <= S_RD_HDR;
					end
				end
				S_WR_HDR: begin
					// Upper header bytes of an 8-bit length are always zero.
					hcnt_q <= hcnt_q + 1'b1;
					if (hcnt_q == lpmf_pkg::hcnt_t'(lpmf_pkg::HEADER_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_RD_HDR: begin
					// The read data holds the header byte requested in the previous cycle.
					if (hcnt_q == lpmf_pkg::hcnt_t'(1)) begin
						b0_q <= mem_rdata;
					end else if (mem_rdata != '0) begin
						hi_q <= 1'b1;
					end
					if (hdr_rd_issue) begin
						rp_q   <= idx_inc(rp_q);
						hcnt_q <= hcnt_q + 1'b1;
					end else begin
						state_q <= S_RD_CHK;
					end
				end
				S_RD_CHK: begin
					if (chk_data) begin
						rp_q    <= idx_inc(rp_q);
						rem_q   <= b0_q;
						state_q <= S_RD_DATA;
					end else if (out_free) begin
						out_res_q   <= '{status: chk_err ? lpmf_pkg::ST_ERROR : lpmf_pkg::ST_ACCEPT,
							out_byte: '0, byte_valid: 1'b0, reported_length: '0, last: 1'b1};
						out_valid_q <= 1'b1;
						if (chk_zero) begin
							ri_q <= rp_q;
						end
						state_q <= S_IDLE;
					end
				end
				S_RD_DATA: begin
					if (data_load) begin
						out_res_q   <= '{status: lpmf_pkg::ST_ACCEPT, out_byte: mem_rdata,
							byte_valid: 1'b1, reported_length: b0_q, last: !data_more};
						out_valid_q <= 1'b1;
						rem_q       <= rem_q - 1'b1;
						if (data_more) begin
							rp_q <= idx_inc(rp_q);
						end else begin
							ri_q    <= rp_q;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/length_prefixed_message_fifo_unit.sv =====
// Top level of the length-prefixed message FIFO: stream ports, ring memory and sequencer.
//
//  Channel  | Direction | Transfer carries
//  ---------+-----------+-----------------------------------------------------------
//  s_*      | in        | tuser = cmd; tdata = msg_length, in_byte
//  m_*      | out       | tuser = status, byte_valid; tdata = out_byte, reported_length;
//           |           | tlast = last
//
// A write data byte and every request refused at acceptance are answered straight from idle.
// An accepted write request writes its header on the RAM write port: the length byte, then zeros.
// A read fetches its header through the registered RAM read port, checks the stored length, then
// returns one byte per cycle while the result register is free or draining. A read refused for its
// stored length, or of an empty message, ends after the check with a single result.
// Input is taken only while the sequencer is idle and the result register is free or draining.
// Reset clears the pointers and counters; the ring memory needs no clearing pass.
module length_prefixed_message_fifo_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] msg_length, [15:8] in_byte
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] reported_length
	output logic [2:0]  m_tuser,   // [1:0] status, [2] byte_valid
	output logic        m_tlast
);

	lpmf_pkg::res_t     res;
	lpmf_pkg::mem_req_t mem_req;
	lpmf_pkg::len_t     mem_rdata;

	lpmf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.cmd        (s_tuser),
		.msg_length (s_tdata[7:0]),
		.in_byte    (s_tdata[15:8]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata)
	);

	lpmf_ram #(
		.WIDTH (lpmf_pkg::LEN_W),
		.DEPTH (lpmf_pkg::BUFFER_BYTES)
	) u_ring (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	assign m_tdata = {res.reported_length, res.out_byte};
	assign m_tuser = {res.byte_valid, res.status};
	assign m_tlast = res.last;

endmodule

// ===== rtl/lpmf_checker.sv =====
// Port-level checks of the message FIFO, bound to the top level.
module lpmf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// Input is only taken when the result register can accept the answer.
	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input ready while a result is stalled");

	// A reserved command is answered in the next cycle with a sequence error.
	a_rsvd_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == lpmf_pkg::CMD_RSVD)) |=>
		(m_tvalid && (m_tuser[1:0] == lpmf_pkg::ST_SEQ) && m_tlast))
		else $error("reserved command not answered with a sequence error");

	// Any non-accept status is a single-result answer with no payload fields.
	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] != lpmf_pkg::ST_ACCEPT)) |->
		(m_tlast && !m_tuser[2] && (m_tdata == 16'd0)))
		else $error("rejected result carries payload");

	// Without a payload byte the byte field reads as zero.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[2]) |-> (m_tdata[7:0] == 8'd0))
		else $error("out_byte nonzero without byte_valid");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast)))
		else $error("stalled result changed");

endmodule

bind length_prefixed_message_fifo_unit lpmf_checker u_lpmf_checker (.*);

// ===== tb/length_prefixed_message_fifo_unit_tb.sv =====
// Self-checking testbench for the length-prefixed message FIFO unit.
module length_prefixed_message_fifo_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int STIM_ITEMS  = 365;
	localparam int IDLE_PCT    = 22;

	class ring_scoreboard;
		lpmf_pkg::len_t ring [lpmf_pkg::BUFFER_BYTES];
		int   head;
		int   tail;
		int   bytes_owed;
		bit   mid_write;
		int   errors;
		lpmf_pkg::res_t due[$];

		function new();
			head = 0;
			tail = 0;
			bytes_owed = 0;
			mid_write = 0;
			errors = 0;
			foreach (ring[i]) ring[i] = '0;
		endfunction

		function int held();
			return (tail - head + lpmf_pkg::BUFFER_BYTES) % lpmf_pkg::BUFFER_BYTES;
		endfunction

		function void push_byte(lpmf_pkg::len_t b);
			ring[tail] = b;
			tail = (tail + 1) % lpmf_pkg::BUFFER_BYTES;
		endfunction

		function void add_result(logic [1:0] st, lpmf_pkg::len_t b, logic v,
			lpmf_pkg::len_t n, logic l);
			lpmf_pkg::res_t r;
			r.status = st;
			r.out_byte = b;
			r.byte_valid = v;
			r.reported_length = n;
			r.last = l;
			due.push_back(r);
		endfunction

		// Length in the header at the read side, or -1 when no whole header is held.
		function int stored_length();
			int n;
			n = 0;
			if (held() < lpmf_pkg::HEADER_BYTES) return -1;
			for (int i = 0; i < lpmf_pkg::HEADER_BYTES; i++)
				n = n | (int'(ring[(head + i) % lpmf_pkg::BUFFER_BYTES]) << (8 * i));
			return n;
		endfunction

		function void take_request(logic [1:0] cmd, lpmf_pkg::len_t len,
			lpmf_pkg::len_t data);
			int n;
			n = 0;
			case (cmd)
				lpmf_pkg::CMD_WR_REQ: begin
					if (mid_write)
						add_result(lpmf_pkg::ST_SEQ, 8'h00, 1'b0, 8'h00, 1'b1);
					else if (lpmf_pkg::HEADER_BYTES + int'(len) > lpmf_pkg::BUFFER_BYTES)
						add_result(lpmf_pkg::ST_ERROR, 8'h00, 1'b0, 8'h00, 1'b1);
					else if (lpmf_pkg::BUFFER_BYTES - held() - 1 <
						lpmf_pkg::HEADER_BYTES + int'(len))
						add_result(lpmf_pkg::ST_BLOCK, 8'h00, 1'b0, 8'h00, 1'b1);
					else begin
						for (int i = 0; i < lpmf_pkg::HEADER_BYTES; i++)
							push_byte(i == 0 ? len : 8'h00);
						bytes_owed = int'(len);
						mid_write = (len != 0);
						add_result(lpmf_pkg::ST_ACCEPT, 8'h00, 1'b0, len, 1'b1);
					end
				end
				lpmf_pkg::CMD_WR_DATA: begin
					if (!mid_write || bytes_owed == 0)
						add_result(lpmf_pkg::ST_SEQ, 8'h00, 1'b0, 8'h00, 1'b1);
					else begin
						push_byte(data);
						bytes_owed--;
						if (bytes_owed == 0) mid_write = 0;
						add_result(lpmf_pkg::ST_ACCEPT, 8'h00, 1'b0, 8'h00, 1'b1);
					end
				end
				lpmf_pkg::CMD_RD_REQ: begin
					if (mid_write)
						add_result(lpmf_pkg::ST_SEQ, 8'h00, 1'b0, 8'h00, 1'b1);
					else if (held() < lpmf_pkg::HEADER_BYTES)
						add_result(lpmf_pkg::ST_BLOCK, 8'h00, 1'b0, 8'h00, 1'b1);
					else begin
						n = stored_length();
						if (n > int'(len) || n > held() - lpmf_pkg::HEADER_BYTES)
							add_result(lpmf_pkg::ST_ERROR, 8'h00, 1'b0, 8'h00, 1'b1);
						else begin
							head = (head + lpmf_pkg::HEADER_BYTES) % lpmf_pkg::BUFFER_BYTES;
							if (n == 0)
								add_result(lpmf_pkg::ST_ACCEPT, 8'h00, 1'b0, 8'h00, 1'b1);
							for (int i = 0; i < n; i++) begin
								add_result(lpmf_pkg::ST_ACCEPT, ring[head], 1'b1,
									lpmf_pkg::len_t'(n), i == n - 1);
								head = (head + 1) % lpmf_pkg::BUFFER_BYTES;
							end
						end
					end
				end
				default: add_result(lpmf_pkg::ST_SEQ, 8'h00, 1'b0, 8'h00, 1'b1);
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("%0t: mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [1:0] st, lpmf_pkg::len_t b, logic v,
			lpmf_pkg::len_t n, logic l);
			lpmf_pkg::res_t want;
			if (due.size() == 0) begin
				report_mismatch($sformatf("result with nothing outstanding, status %0d", st));
				return;
			end
			want = due.pop_front();
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, wanted %0d", st, want.status));
			if (b !== want.out_byte)
				report_mismatch($sformatf("out_byte %0h, wanted %0h", b, want.out_byte));
			if (v !== want.byte_valid)
				report_mismatch($sformatf("byte_valid %0b, wanted %0b", v, want.byte_valid));
			if (n !== want.reported_length)
				report_mismatch($sformatf("reported_length %0d, wanted %0d", n,
					want.reported_length));
			if (l !== want.last)
				report_mismatch($sformatf("last %0b, wanted %0b", l, want.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	ring_scoreboard sb = new();
	bit quiet;
	int sent;
	int cycles;

	length_prefixed_message_fifo_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit idle_draw();
		return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	function automatic lpmf_pkg::len_t rand_byte();
		return lpmf_pkg::len_t'($urandom_range(0, 255));
	endfunction

	// Valid stays high from one transfer to the next unless a gap is drawn.
	task automatic send(logic [1:0] cmd, lpmf_pkg::len_t len, lpmf_pkg::len_t data);
		@(negedge clk);
		if (idle_draw()) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while (idle_draw());
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {data, len};
		do @(posedge clk); while (!s_tready);
		sb.take_request(cmd, len, data);
		sent++;
	endtask

	function automatic lpmf_pkg::len_t pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return lpmf_pkg::len_t'($urandom_range(0, 8));
		if (r < 80) return lpmf_pkg::len_t'($urandom_range(9, 30));
		if (r < 92) return lpmf_pkg::len_t'($urandom_range(31, 59));
		return lpmf_pkg::len_t'($urandom_range(60, 255));
	endfunction

	function automatic lpmf_pkg::len_t pick_capacity();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = sb.stored_length();
		if (r < 55) return 8'hFF;
		if (r < 72 && n >= 0) return lpmf_pkg::len_t'(n);
		if (r < 84 && n > 0) return lpmf_pkg::len_t'(n - 1);
		return rand_byte();
	endfunction

	task automatic send_noise();
		int r;
		r = $urandom_range(0, 2);
		case (r)
			0: send(lpmf_pkg::CMD_RSVD, rand_byte(), rand_byte());
			1: send(lpmf_pkg::CMD_RD_REQ, rand_byte(), rand_byte());
			default: send(lpmf_pkg::CMD_WR_REQ, rand_byte(), rand_byte());
		endcase
	endtask

	initial begin
		m_tready = 1'b0;
		forever @(negedge clk) m_tready <= !idle_draw();
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser[1:0], m_tdata[7:0], m_tuser[2], m_tdata[15:8], m_tlast);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("length_prefixed_message_fifo_unit_tb: FAIL");
			$finish;
		end
	end

	initial begin
		int r;
		bit first_msg;
		lpmf_pkg::len_t len;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		quiet = 1'b0;
		sent = 0;
		cycles = 0;
		first_msg = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		send(lpmf_pkg::CMD_RD_REQ, 8'hFF, 8'h00);   // empty ring blocks
		send(lpmf_pkg::CMD_WR_DATA, 8'h00, 8'hFF);  // data with no message open
		send(lpmf_pkg::CMD_RSVD, 8'hFF, 8'hFF);
		send(lpmf_pkg::CMD_WR_REQ, 8'd61, 8'h00);   // header plus payload exceeds the ring
		send(lpmf_pkg::CMD_WR_REQ, 8'hFF, 8'h00);
		send(lpmf_pkg::CMD_WR_REQ, 8'd60, 8'h00);   // fits the ring but not the free space
		send(lpmf_pkg::CMD_WR_REQ, 8'd0, 8'h00);
		send(lpmf_pkg::CMD_RD_REQ, 8'd0, 8'h00);    // zero-length message
		send(lpmf_pkg::CMD_WR_REQ, 8'd3, 8'h00);
		send(lpmf_pkg::CMD_WR_REQ, 8'd2, 8'h00);    // requests while a message is open
		send(lpmf_pkg::CMD_RD_REQ, 8'hFF, 8'h00);
		send(lpmf_pkg::CMD_WR_DATA, 8'hFF, 8'h00);
		send(lpmf_pkg::CMD_WR_DATA, 8'h00, 8'hFF);
		send(lpmf_pkg::CMD_WR_DATA, 8'h5A, 8'hA5);
		send(lpmf_pkg::CMD_WR_DATA, 8'h00, 8'h11);
		send(lpmf_pkg::CMD_RD_REQ, 8'd2, 8'h00);    // capacity below the stored length
		send(lpmf_pkg::CMD_RD_REQ, 8'd3, 8'h00);
		send(lpmf_pkg::CMD_WR_REQ, 8'd1, 8'h00);
		send(lpmf_pkg::CMD_WR_DATA, 8'h00, 8'h5A);
		send(lpmf_pkg::CMD_WR_REQ, 8'd0, 8'h00);
		send(lpmf_pkg::CMD_RD_REQ, 8'd1, 8'h00);
		send(lpmf_pkg::CMD_RD_REQ, 8'hFF, 8'h00);
		send(lpmf_pkg::CMD_RD_REQ, 8'hFF, 8'h00);

		while (sent < STIM_ITEMS) begin
			quiet = (sent >= 150 && sent < 240);
			r = $urandom_range(0, 99);
			if (first_msg || r < 50) begin
				// The first message fills the ring to its limit.
				len = first_msg ? 8'd59 : pick_length();
				first_msg = 1'b0;
				send(lpmf_pkg::CMD_WR_REQ, len, rand_byte());
				while (sb.bytes_owed != 0) begin
					if ($urandom_range(0, 99) < 6) send_noise();
					send(lpmf_pkg::CMD_WR_DATA, rand_byte(), rand_byte());
				end
			end else if (r < 88)
				send(lpmf_pkg::CMD_RD_REQ, pick_capacity(), rand_byte());
			else if (r < 94)
				send(lpmf_pkg::CMD_WR_DATA, rand_byte(), rand_byte());
			else
				send_noise();
		end
		quiet = 1'b0;

		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (2 * lpmf_pkg::HEADER_BYTES + 8) @(posedge clk);
		if (sb.errors == 0)
			$display("length_prefixed_message_fifo_unit_tb: PASS");
		else
			$display("length_prefixed_message_fifo_unit_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lpmf_pkg.sv
rtl/lpmf_ram.sv
rtl/lpmf_ctrl.sv
rtl/length_prefixed_message_fifo_unit.sv
rtl/lpmf_checker.sv
tb/length_prefixed_message_fifo_unit_tb.sv
